### sv/b64u_pkg.sv
// Package: word types, result codes and the base64url character map.
package b64u_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PAD   = 8'h3D;

  localparam logic [7:0] LO_BASE    = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;
  localparam logic [5:0] VAL_DASH   = 6'd62;
  localparam logic [5:0] VAL_UNDER  = 6'd63;

  typedef enum logic [0:0] {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LEN  = 2'd1,
    ST_CHAR = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       char_present;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    status_e    status;
    logic       last;
  } out_word_t;

  // One accepted character's worth of results: up to three bytes of a
  // 24-bit block (mask bit i emits byte i, most significant first) and an
  // optional closing status.
  typedef struct packed {
    logic [23:0] block;
    logic [2:0]  mask;
    logic        has_status;
    status_e     status;
  } job_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] val;
  } char_map_t;

  function automatic char_map_t char_map(input logic [7:0] c);
    char_map_t m;
    m.bad = 1'b0;
    m.val = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      m.val = 6'(c - CH_UP_A);
    end else if (c inside {[8'h61:8'h7A]}) begin
      m.val = 6'(c - CH_LO_A + LO_BASE);
    end else if (c inside {[8'h30:8'h39]}) begin
      m.val = 6'(c - CH_ZERO + DIGIT_BASE);
    end else if (c == CH_DASH) begin
      m.val = VAL_DASH;
    end else if (c == CH_UNDER) begin
      m.val = VAL_UNDER;
    end else if (c == CH_PAD) begin
      m.val = '0;
    end else begin
      m.bad = 1'b1;
    end
    return m;
  endfunction

endpackage

### sv/b64u_front.sv
// Front end: map characters, track the group, and build result jobs.
module b64u_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  b64u_pkg::in_word_t in_word_i,
  output logic              push_o,
  output b64u_pkg::job_t    job_o
);
  import b64u_pkg::*;

  logic [17:0] bits_q, bits_d;
  logic [1:0]  pos_q, pos_d;
  logic        tip_q, tip_d;
  logic        bad_q, bad_d;
  char_map_t   m;
  logic        is_pad;
  job_t        job;

  always_comb begin
    m      = char_map(in_word_i.in_char);
    is_pad = (in_word_i.in_char == CH_PAD);
    bits_d = bits_q;
    pos_d  = pos_q;
    tip_d  = tip_q;
    bad_d  = bad_q;
    job    = '0;
    job.status = ST_OK;
    if (accept_i) begin
      if (in_word_i.char_present) begin
        bad_d = bad_q | m.bad;
        if (pos_q != 2'd3) begin
          bits_d = {bits_q[11:0], m.val};
          if (pos_q == 2'd2) begin
            tip_d = is_pad;
          end
          pos_d = pos_q + 2'd1;
        end else begin
          if (!bad_d) begin
            job.block = {bits_q, m.val};
            job.mask  = {!is_pad, !tip_q, 1'b1};
          end
          bits_d = '0;
          pos_d  = '0;
          tip_d  = 1'b0;
        end
      end
      if (in_word_i.end_of_string) begin
        job.has_status = 1'b1;
        if (pos_d == 2'd1) begin
          job.status = ST_LEN;
        end else begin
          // pad a partial group and flush its bytes
          if (!bad_d) begin
            case (pos_d)
              2'd2: begin
                job.block = {bits_d[11:0], 12'd0};
                job.mask  = 3'b001;
              end
              2'd3: begin
                job.block = {bits_d, 6'd0};
                job.mask  = {1'b0, !tip_d, 1'b1};
              end
              default: ;
            endcase
          end
          job.status = bad_d ? ST_CHAR : ST_OK;
        end
        bits_d = '0;
        pos_d  = '0;
        tip_d  = 1'b0;
        bad_d  = 1'b0;
      end
    end
  end

  assign job_o  = job;
  assign push_o = accept_i && ((job.mask != 3'b000) || job.has_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      pos_q  <= '0;
      tip_q  <= 1'b0;
      bad_q  <= 1'b0;
    end else begin
      bits_q <= bits_d;
      pos_q  <= pos_d;
      tip_q  <= tip_d;
      bad_q  <= bad_d;
    end
  end

endmodule

### sv/b64u_queue.sv
// Job queue between the front end and the back end.
module b64u_queue #(
  parameter int unsigned Depth = b64u_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64u_pkg::job_t push_job_i,
  input  logic           pop_i,
  output b64u_pkg::job_t pop_job_o,
  output logic           full_o,
  output logic           empty_o
);
  import b64u_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pop_job_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/b64u_back.sv
// Back end: serialize each job into result words through an output register.
module b64u_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  b64u_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64u_pkg::out_word_t out_word_o
);
  import b64u_pkg::*;

  job_t      job_q;
  logic [3:0] pend_q, pend_d;
  logic [3:0] pick;
  logic [3:0] pend_after;
  logic       adv, load;
  out_word_t  res;
  out_word_t  out_q;
  logic       out_valid_q;

  always_comb begin
    pick = 4'b0000;
    if (pend_q[0]) begin
      pick = 4'b0001;
    end else if (pend_q[1]) begin
      pick = 4'b0010;
    end else if (pend_q[2]) begin
      pick = 4'b0100;
    end else if (pend_q[3]) begin
      pick = 4'b1000;
    end
  end

  assign adv        = (pend_q != 4'b0000) && (!out_valid_q || out_ready_i);
  assign pend_after = adv ? (pend_q & ~pick) : pend_q;
  assign load       = (pend_after == 4'b0000) && job_valid_i;
  assign job_pop_o  = load;

  always_comb begin
    res.out_byte = '0;
    res.kind     = KIND_DATA;
    res.status   = ST_OK;
    res.last     = (pend_after == 4'b0000);
    if (pick[0]) begin
      res.out_byte = job_q.block[23:16];
    end else if (pick[1]) begin
      res.out_byte = job_q.block[15:8];
    end else if (pick[2]) begin
      res.out_byte = job_q.block[7:0];
    end else begin
      res.kind   = KIND_STATUS;
      res.status = job_q.status;
    end
  end

  always_comb begin
    pend_d = pend_after;
    if (load) begin
      pend_d = {job_i.has_status, job_i.mask};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### sv/base64url_decoder.sv
// Streaming base64url decoder: one character word in, decoded byte and status words out.
// The decoder takes one character word per clock cycle when the job queue has room,
// and delivers one result word per cycle from its output register while the receiver
// is ready. A group of four characters yields at most three bytes, so a steady character
// stream runs at one word per cycle. The output side limits the rate only when a single
// input word causes several results. A character that completes a group and also ends
// the string causes up to four: the group's bytes and the status. The job queue
// (QueueDepth entries) then absorbs the burst before input ready drops. Each accepted
// character's job is queued, then loaded by the back end, which registers its results.
// The front end maps characters and tracks the current group; the back end turns each
// queued job into its data words and any closing status word, flagging the last one.
module base64url_decoder #(
  parameter int unsigned QueueDepth = b64u_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b64u_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b64u_pkg::out_word_t out_word_o
);
  import b64u_pkg::*;

  logic q_full, q_empty;
  logic accept;
  logic push, pop;
  job_t push_job, pop_job;

  // Take a new word whenever the queue can hold the job it may produce.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  b64u_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .push_o    (push),
    .job_o     (push_job)
  );

  b64u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  b64u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // A status word always closes the results of its input word.
  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_STATUS) |-> out_word_o.last)
    else $error("status word without last");

  // Data words carry a zero status, status words a zero byte.
  a_field_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_word_o.kind == KIND_DATA) && (out_word_o.status == ST_OK)) ||
                    ((out_word_o.kind == KIND_STATUS) && (out_word_o.out_byte == 8'd0)))
    else $error("result word fields inconsistent");

  // Jobs are popped only from a non-empty queue.
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

### verif/decode_checker.sv
// Checker for base64url_decoder: predicts the decoded byte and status words and compares them.
module decode_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  b64u_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  b64u_pkg::out_word_t out_word_i,
  input  logic                done_i,
  output int unsigned         pending_o,
  output int unsigned         mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import b64u_pkg::*;

  // Words still owed by the decoder, oldest first.
  out_word_t decoded_words[$];

  // Decoder state as the predictor sees it.
  logic [17:0] sextets;
  logic [1:0]  group_pos;
  logic        third_pad;
  logic        bad_seen;
  logic        leftovers_done;
  out_word_t   want;

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  // Map one character to {bad, value}; '=' counts as zero.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= CH_UP_A && c < CH_UP_A + 8'd26) begin
      return {1'b0, 6'(c - CH_UP_A)};
    end else if (c >= CH_LO_A && c < CH_LO_A + 8'd26) begin
      return {1'b0, 6'(c - CH_LO_A + LO_BASE)};
    end else if (c >= CH_ZERO && c < CH_ZERO + 8'd10) begin
      return {1'b0, 6'(c - CH_ZERO + DIGIT_BASE)};
    end else if (c == CH_DASH) begin
      return {1'b0, VAL_DASH};
    end else if (c == CH_UNDER) begin
      return {1'b0, VAL_UNDER};
    end else if (c == CH_PAD) begin
      return 7'd0;
    end
    return {1'b1, 6'd0};
  endfunction

  function automatic out_word_t byte_word(input logic [7:0] b);
    out_word_t w;
    w.out_byte = b;
    w.kind     = KIND_DATA;
    w.status   = ST_OK;
    w.last     = 1'b0;
    return w;
  endfunction

  // Advance the predicted state by one accepted word and queue what it yields.
  task automatic decode_char(input in_word_t w);
    out_word_t   batch[$];
    out_word_t   closing;
    logic [6:0]  m;
    logic [23:0] blk;
    logic        is_pad;
    if (w.char_present) begin
      m = sextet_of(w.in_char);
      is_pad = (w.in_char == CH_PAD);
      if (m[6]) begin
        bad_seen = 1'b1;
      end
      if (group_pos < 2'd3) begin
        sextets = {sextets[11:0], m[5:0]};
        if (group_pos == 2'd2) begin
          third_pad = is_pad;
        end
        group_pos = group_pos + 2'd1;
      end else begin
        blk = {sextets, m[5:0]};
        if (!bad_seen) begin
          batch = {batch, byte_word(blk[23:16])};
          if (!third_pad) begin
            batch = {batch, byte_word(blk[15:8])};
          end
          if (!is_pad) begin
            batch = {batch, byte_word(blk[7:0])};
          end
        end
        sextets   = '0;
        group_pos = '0;
        third_pad = 1'b0;
      end
    end
    if (w.end_of_string) begin
      closing.out_byte = 8'h00;
      closing.kind     = KIND_STATUS;
      closing.last     = 1'b0;
      if (group_pos == 2'd1) begin
        closing.status = ST_LEN;
      end else begin
        // Pad a partial group of two or three characters.
        if (!bad_seen && group_pos == 2'd2) begin
          batch = {batch, byte_word(sextets[11:4])};
        end else if (!bad_seen && group_pos == 2'd3) begin
          batch = {batch, byte_word(sextets[17:10])};
          if (!third_pad) begin
            batch = {batch, byte_word(sextets[9:2])};
          end
        end
        closing.status = bad_seen ? ST_CHAR : ST_OK;
      end
      batch = {batch, closing};
      sextets   = '0;
      group_pos = '0;
      third_pad = 1'b0;
      bad_seen  = 1'b0;
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[i]) begin
      decoded_words = {decoded_words, batch[i]};
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      decoded_words.delete();
      sextets        = '0;
      group_pos      = '0;
      third_pad      = 1'b0;
      bad_seen       = 1'b0;
      leftovers_done = 1'b0;
      mismatches_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_char(in_word_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (decoded_words.size() == 0) begin
          report($sformatf("unexpected word byte=%02h kind=%0d status=%0d last=%0b",
                           out_word_i.out_byte, out_word_i.kind, out_word_i.status,
                           out_word_i.last));
        end else begin
          want = decoded_words.pop_front();
          if (out_word_i.out_byte !== want.out_byte) begin
            report($sformatf("out_byte %02h, want %02h", out_word_i.out_byte, want.out_byte));
          end
          if (out_word_i.kind !== want.kind) begin
            report($sformatf("kind %0d, want %0d", out_word_i.kind, want.kind));
          end
          if (out_word_i.status !== want.status) begin
            report($sformatf("status %0d, want %0d", out_word_i.status, want.status));
          end
          if (out_word_i.last !== want.last) begin
            report($sformatf("last %0b, want %0b", out_word_i.last, want.last));
          end
        end
      end
      if (done_i && !leftovers_done) begin
        foreach (decoded_words[i]) begin
          report($sformatf("missing word byte=%02h kind=%0d status=%0d",
                           decoded_words[i].out_byte, decoded_words[i].kind,
                           decoded_words[i].status));
        end
        decoded_words.delete();
        leftovers_done = 1'b1;
      end
    end
    pending_o = decoded_words.size();
  end

endmodule

### verif/tb.sv
// Testbench top for base64url_decoder: stimulus, handshake pacing and the final verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64u_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 175;
  // Receiver hold-off: start (cycles after reset) and length.
  localparam int unsigned HOLD_START   = 120;
  localparam int unsigned HOLD_CYCLES  = 48;
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        done = 1'b0;
  int unsigned pending;
  int unsigned mismatches;

  // Encoded character words to send, in order.
  in_word_t    encoded_words[$];
  int unsigned string_items = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  base64url_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  decode_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .done_i      (done),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  // Queue one word; count only words the decoder does not simply ignore.
  task automatic add_word(input logic [7:0] c, input logic present, input logic eos);
    in_word_t w;
    w.in_char       = c;
    w.char_present  = present;
    w.end_of_string = eos;
    encoded_words = {encoded_words, w};
    if (present || eos) begin
      string_items++;
    end
  endtask

  // Queue a literal string; close it on its last character or not at all.
  task automatic add_text(input string s, input bit close_on_last);
    for (int i = 0; i < s.len(); i++) begin
      add_word(s[i], 1'b1, close_on_last && (i == s.len() - 1));
    end
  endtask

  // Turn a 6-bit value into its alphabet character.
  function automatic logic [7:0] alpha_char(input int unsigned v);
    if (v < 26) begin
      return CH_UP_A + 8'(v);
    end else if (v < 52) begin
      return CH_LO_A + 8'(v - 26);
    end else if (v < 62) begin
      return CH_ZERO + 8'(v - 52);
    end else if (v == 62) begin
      return CH_DASH;
    end
    return CH_UNDER;
  endfunction

  // Pick a byte outside the alphabet; fold alphabet hits into the upper half.
  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if ((c >= CH_UP_A && c < CH_UP_A + 8'd26) || (c >= CH_LO_A && c < CH_LO_A + 8'd26) ||
        (c >= CH_ZERO && c < CH_ZERO + 8'd10) || c == CH_DASH || c == CH_UNDER ||
        c == CH_PAD) begin
      c[7] = 1'b1;
    end
    return c;
  endfunction

  // Mostly well-formed strings with random content; some carry a bad character,
  // a stray pad or an odd length, and idle words are sprinkled in between.
  task automatic add_random_string();
    logic [7:0] text[$];
    int unsigned len;
    int unsigned flavor;
    bit          close_on_last;
    len = $urandom_range(0, 13);
    flavor = $urandom_range(0, 9);
    close_on_last = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      text = {text, alpha_char($urandom_range(0, 63))};
    end
    // Pad a full final group with one or two '=', or a partial group of three.
    if (len > 0 && len % 4 == 0 && $urandom_range(0, 1) == 1) begin
      text[len - 1] = CH_PAD;
      if ($urandom_range(0, 1) == 1) begin
        text[len - 2] = CH_PAD;
      end
    end else if (len % 4 == 3 && $urandom_range(0, 3) == 0) begin
      text[len - 1] = CH_PAD;
    end
    if (len > 0 && flavor == 8) begin
      text[$urandom_range(0, len - 1)] = bad_char();
    end
    if (len > 0 && flavor == 9) begin
      text[$urandom_range(0, len - 1)] = CH_PAD;
    end
    foreach (text[i]) begin
      if ($urandom_range(0, 11) == 0) begin
        add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      add_word(text[i], 1'b1, close_on_last && (i == len - 1));
    end
    // Close with a bare end marker when the last character did not.
    if (!(close_on_last && len > 0)) begin
      add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic build_stimulus();
    int unsigned base;
    // Full group, three bytes.
    add_text("TWFu", 1'b1);
    // Top alphabet values, fourth character a pad, closed by a bare end marker.
    add_text("_-8=", 1'b0);
    add_word(8'hFF, 1'b0, 1'b1);
    // Third and fourth characters padded: one byte.
    add_text("AZ==", 1'b1);
    // Empty string: status only.
    add_word(8'h00, 1'b0, 1'b1);
    // Lone trailing character: length error.
    add_text("Q", 1'b1);
    // Partial group of three.
    add_text("az0", 1'b1);
    // Bad character (all zeros) in a partial group of three.
    add_word("a", 1'b1, 1'b0);
    add_word(8'h00, 1'b1, 1'b0);
    add_word("b", 1'b1, 1'b1);
    // Idle word: ignored.
    add_word(8'hA5, 1'b0, 1'b0);
    // Bad character (all ones) ending a partial group of two.
    add_word("k", 1'b1, 1'b0);
    add_word(8'hFF, 1'b1, 1'b1);
    // Length error wins over a bad character.
    add_word(8'h80, 1'b1, 1'b1);
    base = string_items;
    while (string_items - base < RANDOM_ITEMS) begin
      add_random_string();
    end
  endtask

  // Hold reset, then release it once.
  initial begin : reset_gen
    repeat (RESET_CYCLES) @(posedge clk);
    rst_ni <= 1'b1;
  end

  // Sender: bursts of random length with random gaps; hold a word until it is taken.
  initial begin : sender
    int unsigned sent;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned waited;
    sent = 0;
    burst_left = 0;
    gap_left = 0;
    waited = 0;
    build_stimulus();
    wait (rst_ni === 1'b1);
    while (sent < encoded_words.size()) begin
      @(posedge clk);
      if (in_valid && in_ready) begin
        sent++;
      end
      if (in_valid && !in_ready) begin
        // Hold valid and the word until accepted.
      end else if (sent == encoded_words.size()) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else begin
        in_valid <= 1'b1;
        in_word  <= encoded_words[sent];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // Start a new burst; a third of the time without any gap.
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    // Drain: wait until nothing is owed, then give stray words a chance to show.
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    done <= 1'b1;
    repeat (3) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: stall on phases of its own pattern, plus one long hold-off while the
  // sender keeps offering, so the job queue fills and input ready drops.
  initial begin : receiver
    int unsigned cycle;
    int unsigned phase_left;
    int unsigned mode;
    cycle = 0;
    phase_left = 0;
    mode = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk);
      cycle++;
      if (phase_left == 0) begin
        phase_left = $urandom_range(1, 30);
        mode = $urandom_range(0, 3);
      end
      phase_left--;
      if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) begin
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (cycle % 4 == 0);
          default: out_ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Give up on a hung run.
  initial begin : watchdog
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
